@@ rtl/postfix_expression_evaluator_macros.svh @@
// Assertion macros used by the evaluator.
// Each macro takes a label, the clock, the reset, a property expression and a message.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define PFX_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define PFX_NEVER(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error(msg);

`else

`define PFX_ASSERT(lbl, ck, rs, prop, msg)
`define PFX_NEVER(lbl, ck, rs, cond, msg)

`endif

`endif

@@ rtl/pfx_pkg.sv @@
package pfx_pkg;

  localparam int PFX_STACK_DEPTH = 16;
  localparam int DATA_W = 32;

  localparam logic [7:0] SYM_0   = 8'h30;
  localparam logic [7:0] SYM_9   = 8'h39;
  localparam logic [7:0] SYM_MOD = 8'h25;
  localparam logic [7:0] SYM_ADD = 8'h2B;
  localparam logic [7:0] SYM_SUB = 8'h2D;
  localparam logic [7:0] SYM_MUL = 8'h2A;
  localparam logic [7:0] SYM_DIV = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZ    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_MUL,
    S_DIV,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [4:0]         stack_depth;
    logic [2:0]         status;
    logic               done_res;
  } out_word_t;

  // Result of the divider, valid in the cycle that done is high.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

  function automatic op_t decode_sym(logic [7:0] s);
    op_t op;
    unique case (s) inside
      [SYM_0:SYM_9]: op = OP_DIGIT;
      SYM_ADD:       op = OP_ADD;
      SYM_SUB:       op = OP_SUB;
      SYM_MUL:       op = OP_MUL;
      SYM_DIV:       op = OP_DIV;
      SYM_MOD:       op = OP_MOD;
      default:       op = OP_BAD;
    endcase
    return op;
  endfunction

endpackage

@@ rtl/pfx_stack_mem.sv @@
module pfx_stack_mem
  import pfx_pkg::*;
#(
  parameter int Depth = PFX_STACK_DEPTH,
  parameter int AddrW = $clog2(PFX_STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AddrW-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AddrW-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pfx_divider.sv @@
module pfx_divider
  import pfx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output div_rsp_t          rsp
);

  localparam int CntW = $clog2(DATA_W);

  logic              busy;
  logic              done;
  logic [CntW-1:0]   cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] den;
  logic              neg_q;
  logic              neg_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CntW'(1);
        if (cnt == CntW'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
      den   <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
      rem   <= '0;
      neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      neg_r <= dividend[DATA_W-1];
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Signs follow truncating division: the remainder takes the dividend's sign.
  assign rsp.done      = done;
  assign rsp.quotient  = neg_q ? (~quo + DATA_W'(1)) : quo;
  assign rsp.remainder = neg_r ? (~rem + DATA_W'(1)) : rem;

endmodule

@@ rtl/postfix_expression_evaluator.sv @@
// Postfix (RPN) expression evaluator. Each input word carries one ASCII symbol and a last
// flag; every word yields exactly one result word with the value on top of the stack
// (0 when empty), the depth after the symbol, a status code and a done flag. Digits push
// their value, and + - * / % pop two operands and push (second op first) with 32-bit
// wrap-around and C truncating division. Errors (underflow, full stack, divide by zero,
// unknown symbol) leave the stack untouched. A word marked last returns the top and
// empties the stack. The block works on one word at a time: digits and errors finish in
// decode, + and - in the fetch state, * in a multiply state after it, and / and % when the
// divider, which makes one quotient bit per cycle, reports done. The result word is then
// offered once the output register is free, and only after that is the next symbol
// taken. Operand fetch uses the stack memory's registered read port. No clearing pass
// follows reset.
module postfix_expression_evaluator
  import pfx_pkg::*;
#(
  parameter int StackDepth = PFX_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      sym_valid,
  output logic      sym_stall,
  input  in_word_t  sym_word,
  output logic      res_valid,
  input  logic      res_stall,
  output out_word_t res_word
);

`include "postfix_expression_evaluator_macros.svh"

  localparam int SpW   = $clog2(StackDepth + 1);
  localparam int AddrW = $clog2(StackDepth);

  // Control state.
  state_t          state;
  state_t          state_next;
  logic [SpW-1:0]  sp;
  logic [SpW-1:0]  sp_next;

  // The word being worked on.
  op_t             op_q;
  logic [3:0]      digit_q;
  logic            last_q;

  // Copy of the top entry, so that the top never needs a memory read.
  logic [DATA_W-1:0] tos;
  logic [DATA_W-1:0] tos_next;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] prod_next;
  out_word_t         res_q;
  out_word_t         res_next;

  // Memory and divider hookup.
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [SpW-1:0]    sp_m1;
  logic [SpW-1:0]    sp_m2;
  logic [DATA_W-1:0] rd_a;
  logic              div_start;
  div_rsp_t          div_rsp;

  // Finishing an item.
  logic              fin;
  status_t           fin_status;
  logic [SpW-1:0]    fin_depth;
  logic [DATA_W-1:0] fin_top;
  logic [SpW+4:0]    depth_ext;
  logic              out_free;

  assign sp_m1 = sp - SpW'(1);
  assign sp_m2 = sp - SpW'(2);

  // The second operand sits two below the pointer. It is addressed all the time, so the
  // data is ready in the cycle after decode; writes only happen as an item finishes.
  pfx_stack_mem #(
    .Depth (StackDepth),
    .AddrW (AddrW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (sp_m2[AddrW-1:0]),
    .rdata (rd_a)
  );

  pfx_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_a),
    .divisor  (tos),
    .rsp      (div_rsp)
  );

  // New words are taken only between items.
  assign sym_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    tos   <= tos_next;
    prod  <= prod_next;
    res_q <= res_next;
    if (sym_valid && !sym_stall) begin
      op_q    <= decode_sym(sym_word.symbol);
      digit_q <= sym_word.symbol[3:0];
      last_q  <= sym_word.last;
    end
  end

  always_comb begin
    state_next = state;
    sp_next    = sp;
    tos_next   = tos;
    prod_next  = prod;
    res_next   = res_q;
    mem_we     = 1'b0;
    mem_waddr  = sp[AddrW-1:0];
    mem_wdata  = {28'd0, digit_q};
    div_start  = 1'b0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_depth  = sp;
    fin_top    = tos;

    unique case (state)
      S_IDLE: begin
        if (sym_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        fin = 1'b1;
        if (op_q == OP_DIGIT) begin
          if (sp >= SpW'(StackDepth)) begin
            fin_status = ST_OVER;
          end else begin
            mem_we    = 1'b1;
            sp_next   = sp + SpW'(1);
            tos_next  = {28'd0, digit_q};
            fin_depth = sp + SpW'(1);
            fin_top   = {28'd0, digit_q};
          end
        end else if (op_q == OP_BAD) begin
          fin_status = ST_UNKNOWN;
        end else if (sp < SpW'(2)) begin
          fin_status = ST_UNDER;
        end else if ((op_q == OP_DIV || op_q == OP_MOD) && tos == '0) begin
          fin_status = ST_DIVZ;
        end else begin
          fin        = 1'b0;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        prod_next = DATA_W'(rd_a * tos);
        if (op_q == OP_ADD || op_q == OP_SUB) begin
          fin       = 1'b1;
          fin_top   = (op_q == OP_ADD) ? (rd_a + tos) : (rd_a - tos);
        end else if (op_q == OP_MUL) begin
          state_next = S_MUL;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_MUL: begin
        fin     = 1'b1;
        fin_top = prod;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fin     = 1'b1;
          fin_top = (op_q == OP_MOD) ? div_rsp.remainder : div_rsp.quotient;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A finished operator writes its result over the second operand and drops one entry.
    if (fin && state != S_DECODE) begin
      mem_we    = 1'b1;
      mem_waddr = sp_m2[AddrW-1:0];
      mem_wdata = fin_top;
      sp_next   = sp_m1;
      tos_next  = fin_top;
      fin_depth = sp_m1;
    end

    depth_ext = {5'd0, fin_depth};
    if (fin) begin
      res_next.top_value   = (fin_depth != '0) ? fin_top : '0;
      res_next.stack_depth = depth_ext[4:0];
      res_next.status      = fin_status;
      res_next.done_res    = last_q;
      state_next           = S_RESP;
      if (last_q) begin
        sp_next = '0;
      end
    end
  end

  // Output register: holds a result word until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      res_word <= res_q;
    end
  end

  `PFX_ASSERT(a_sp_bound, clk, rst, sp <= SpW'(StackDepth), "stack pointer beyond capacity")
  `PFX_ASSERT(a_last_clears, clk, rst, (state == S_RESP && res_q.done_res) |-> (sp == '0), "stack not emptied after last word")
  `PFX_ASSERT(a_div_done_state, clk, rst, div_rsp.done |-> (state == S_DIV), "divider finished outside a division")
  `PFX_NEVER(a_op_underflow, clk, rst, (state == S_FETCH) && (sp < SpW'(2)), "operand fetch with fewer than two entries")

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import pfx_pkg::*;

  // Longest run of cycles in which no word moves on either channel before the run is
  // declared hung. A divide keeps both channels quiet until its result is offered.
  // Random stalls and gaps at 53 percent add short runs on top of that. This limit is
  // far beyond any of it.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles to watch for stray results once every predicted result has arrived.
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned WORDS_PER_PHASE = 118;

  localparam logic [7:0] OPERATORS [5] = '{SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_MOD};

  // Opening sequence. It covers underflow on an empty stack, divide and remainder by
  // zero, unknown codes at both ends of the byte range, every operator, a remainder with
  // a negative dividend, and three final words: an unknown symbol, an underflow on an
  // empty stack and a lone digit.
  localparam int unsigned OPENING_LEN = 23;
  localparam int unsigned OPENING_FIRST_LAST = 20;
  localparam logic [7:0] OPENING [OPENING_LEN] = '{
    SYM_ADD, SYM_9, SYM_0, SYM_DIV, SYM_MOD, 8'hFF, 8'h00, SYM_SUB,
    SYM_0 + 8'd3, SYM_MUL, SYM_0 + 8'd7, SYM_DIV, SYM_0 + 8'd2, SYM_MOD,
    SYM_0, SYM_9, SYM_SUB, SYM_ADD, SYM_0 + 8'd3, SYM_MOD,
    SYM_9 + 8'd1, SYM_MUL, SYM_0 + 8'd5
  };

  // Tracks the evaluator's stack and holds the results it must produce, oldest first.
  class rpn_scoreboard;
    logic [31:0] held_values [PFX_STACK_DEPTH];
    int unsigned held_count;
    out_word_t   expected_results [$];
    int unsigned errors;
    int unsigned checked;

    // Applies one accepted symbol to the stack and queues the result word it must yield.
    function void note_word(in_word_t w);
      logic [31:0] lhs, rhs, mag_n, mag_d, quo, rem, res;
      status_t     status;
      out_word_t   want;
      status = ST_OK;
      res = '0;
      case (w.symbol) inside
        SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_MOD: begin
          if (held_count < 2) begin
            status = ST_UNDER;
          end else begin
            rhs = held_values[held_count - 1];
            lhs = held_values[held_count - 2];
            if ((w.symbol == SYM_DIV || w.symbol == SYM_MOD) && rhs == '0) begin
              status = ST_DIVZ;
            end else begin
              // Divide on magnitudes, then restore the sign. The quotient is negative
              // when the operand signs differ. The remainder follows the dividend.
              // The most negative value over minus one wraps back onto itself.
              mag_n = lhs[31] ? -lhs : lhs;
              mag_d = rhs[31] ? -rhs : rhs;
              case (w.symbol)
                SYM_ADD: res = lhs + rhs;
                SYM_SUB: res = lhs - rhs;
                SYM_MUL: res = lhs * rhs;
                SYM_DIV: begin
                  quo = mag_n / mag_d;
                  res = (lhs[31] ^ rhs[31]) ? -quo : quo;
                end
                default: begin
                  rem = mag_n % mag_d;
                  res = lhs[31] ? -rem : rem;
                end
              endcase
              held_count--;
              held_values[held_count - 1] = res;
            end
          end
        end
        default: begin
          if (w.symbol >= SYM_0 && w.symbol <= SYM_9) begin
            if (held_count >= PFX_STACK_DEPTH) begin
              status = ST_OVER;
            end else begin
              held_values[held_count] = 32'(w.symbol - SYM_0);
              held_count++;
            end
          end else begin
            status = ST_UNKNOWN;
          end
        end
      endcase
      want.top_value   = (held_count > 0) ? held_values[held_count - 1] : '0;
      want.stack_depth = 5'(held_count);
      want.status      = status;
      want.done_res    = w.last;
      if (w.last) held_count = 0;
      expected_results.push_back(want);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at result %0d, time %0t: %s", checked, $time, what);
      errors++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result word arrived with no symbol pending");
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.top_value !== want.top_value)
        report_mismatch($sformatf("top_value %0d, predicted %0d",
                                  got.top_value, want.top_value));
      if (got.stack_depth !== want.stack_depth)
        report_mismatch($sformatf("stack_depth %0d, predicted %0d",
                                  got.stack_depth, want.stack_depth));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.done_res !== want.done_res)
        report_mismatch($sformatf("done_res %0b, predicted %0b",
                                  got.done_res, want.done_res));
    endtask
  endclass

  logic      clk;
  logic      rst = 1'b1;
  logic      sym_valid = 1'b0;
  logic      sym_stall;
  in_word_t  sym_word = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_word_t res_word;

  rpn_scoreboard book = new();

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned idle_cycles = 0;
  int unsigned words_sent = 0;
  int unsigned noise_sent = 0;

  postfix_expression_evaluator u_top (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .sym_word  (sym_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver decides its stall afresh at every falling edge.
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  // Every result word taken by the receiver is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) book.check_result(res_word);
  end

  always @(posedge clk) begin
    if (rst || (sym_valid && !sym_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Watchdog: no word moved for %0d cycles, %0d results still pending",
             WATCHDOG_LIMIT, book.pending());
    $display("testbench: errors");
    $finish;
  end

  function automatic in_word_t make_word(logic [7:0] symbol, logic last);
    in_word_t w;
    w.symbol = symbol;
    w.last   = last;
    return w;
  endfunction

  function automatic logic [7:0] random_digit();
    return SYM_0 + 8'($urandom_range(9, 0));
  endfunction

  // Any byte that is neither a digit nor an operator.
  function automatic logic [7:0] random_noise();
    logic [7:0] s;
    do s = 8'($urandom_range(255, 0));
    while ((s >= SYM_0 && s <= SYM_9) || s == SYM_ADD || s == SYM_SUB || s == SYM_MUL ||
           s == SYM_DIV || s == SYM_MOD);
    return s;
  endfunction

  // Offers one word from the falling edge, after a random number of idle cycles, and
  // returns at the rising edge that accepts it. Valid stays high on return, so the next
  // call either replaces the word or lowers valid at the following falling edge.
  task automatic send_word(in_word_t w);
    @(negedge clk);
    while ($urandom_range(99, 0) < gap_pct) begin
      sym_valid <= 1'b0;
      @(negedge clk);
    end
    sym_valid <= 1'b1;
    sym_word  <= w;
    @(posedge clk);
    while (sym_stall) @(posedge clk);
    book.note_word(w);
  endtask

  task automatic hold_sender();
    @(negedge clk);
    sym_valid <= 1'b0;
  endtask

  task automatic send_sequence(in_word_t seq [$]);
    foreach (seq[i]) send_word(seq[i]);
    words_sent += seq.size();
  endtask

  // A well-formed expression with n_ops operators and random digits. Its depth stays
  // below the capacity, and an unknown symbol slips in now and then. Some expressions
  // lean hard on multiplication so that results wrap and reach large magnitudes. With
  // no operators the expression is a lone digit.
  task automatic run_expression(int unsigned n_ops);
    in_word_t    seq [$];
    int unsigned held;
    int unsigned done_ops;
    int unsigned mul_weight;
    held = 0;
    done_ops = 0;
    mul_weight = ($urandom_range(3, 0) == 0) ? 7 : 0;
    while (held == 0 || done_ops < n_ops || held > 1) begin
      if ($urandom_range(29, 0) == 0) seq.push_back(make_word(random_noise(), 1'b0));
      if (held < 2 || (done_ops < n_ops && held < 15 && $urandom_range(2, 0) == 0)) begin
        seq.push_back(make_word(random_digit(), 1'b0));
        held++;
      end else begin
        if ($urandom_range(9, 0) < mul_weight) begin
          seq.push_back(make_word(SYM_MUL, 1'b0));
        end else begin
          seq.push_back(make_word(OPERATORS[$urandom_range(4, 0)], 1'b0));
        end
        held--;
        done_ops++;
      end
    end
    seq[seq.size() - 1].last = 1'b1;
    send_sequence(seq);
  endtask

  // Fills the stack past its capacity. The extra digits are refused as overflow. A few
  // operators then follow, and the last of them closes the expression.
  task automatic run_overflow();
    in_word_t seq [$];
    repeat (PFX_STACK_DEPTH + $urandom_range(3, 1)) seq.push_back(make_word(random_digit(), 1'b0));
    repeat ($urandom_range(4, 1)) seq.push_back(make_word(OPERATORS[$urandom_range(4, 0)], 1'b0));
    seq[seq.size() - 1].last = 1'b1;
    send_sequence(seq);
  endtask

  // Builds 8 to the tenth times 2, which wraps to the most negative value. Then it builds
  // 0 - 1 and ends with a divide or a remainder of the first by the second.
  task automatic run_min_by_minus_one();
    in_word_t seq [$];
    repeat (10) seq.push_back(make_word(SYM_0 + 8'd8, 1'b0));
    repeat (9) seq.push_back(make_word(SYM_MUL, 1'b0));
    seq.push_back(make_word(SYM_0 + 8'd2, 1'b0));
    seq.push_back(make_word(SYM_MUL, 1'b0));
    seq.push_back(make_word(SYM_0, 1'b0));
    seq.push_back(make_word(SYM_0 + 8'd1, 1'b0));
    seq.push_back(make_word(SYM_SUB, 1'b0));
    seq.push_back(make_word($urandom_range(1, 0) ? SYM_DIV : SYM_MOD, 1'b1));
    send_sequence(seq);
  endtask

  initial begin
    in_word_t    opening [$];
    int unsigned phase_target;
    int unsigned kind;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < OPENING_LEN; i++)
      opening.push_back(make_word(OPENING[i], i >= OPENING_FIRST_LAST));
    send_sequence(opening);

    // Four idling phases: none at all, then a sender that is idle about half the time,
    // then a receiver that stalls about half the time, then both at a lighter rate. Each
    // phase opens with the sender quiet until every pending result has drained.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 53; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 53; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      hold_sender();
      while (book.pending() != 0) @(posedge clk);
      phase_target = words_sent + WORDS_PER_PHASE;
      while (words_sent < phase_target) begin
        kind = $urandom_range(99, 0);
        if (kind < 70) begin
          run_expression(($urandom_range(9, 0) == 0) ? $urandom_range(14, 9)
                                                     : $urandom_range(8, 0));
        end else if (kind < 80) begin
          run_overflow();
        end else if (kind < 84) begin
          run_min_by_minus_one();
        end else begin
          // Raw bytes with a random last flag, digits and operators included. They
          // exercise every bit of the symbol and the error paths out of sequence.
          repeat ($urandom_range(4, 1)) begin
            send_word(make_word(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0))));
            noise_sent++;
          end
        end
      end
    end

    hold_sender();
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d expression words and %0d raw noise words over four idling phases.",
             words_sent, noise_sent);
    $display("Compared %0d result words; %0d field mismatches.", book.checked, book.errors);
    if (book.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
